// ----- hdl/lfr_pkg.sv -----
package lfr_pkg;

    // Held-header counter width: the header span from the checksum field on is at most 50 bytes.
    localparam int CNT_W  = 6;
    // Frame positions saturate at 127; limits go up to 128.
    localparam int POS_W  = 7;
    localparam int LIM_W  = 8;
    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // One queue entry: a plain byte, or a flush of the held header.
    // For a flush, data is the final checksum and cnt the number of bytes to send.
    typedef struct packed {
        logic             is_flush;
        logic [15:0]      data;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_cmd;

endpackage

// ----- hdl/lfr_ram.sv -----
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lfr_queue.sv -----
module lfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lfr_pkg::t_cmd o_head,
    output logic          o_empty
);

    import lfr_pkg::*;

    localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W+1)'(QDEPTH);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/lfr_front.sv -----
module lfr_front #(
    parameter int MIN_FRAME  = 60,
    parameter int HOLD_DEPTH = 50,
    parameter int AW         = $clog2(HOLD_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [47:0]       i_local_mac,
    input  logic [47:0]       i_peer_mac,
    input  logic [31:0]       i_flip_mask,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lfr_pkg::t_in_item i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output lfr_pkg::t_cmd     o_q_cmd,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output logic [7:0]        o_ram_wdata
);

    import lfr_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX     = 7'd127;
    localparam logic [POS_W-1:0] DST_MAC_END = 7'd6;
    localparam logic [POS_W-1:0] SRC_MAC_END = 7'd12;
    localparam logic [POS_W-1:0] HDR_START   = 7'd14;
    localparam logic [POS_W-1:0] CSUM_POS    = 7'd24;
    localparam logic [POS_W-1:0] CSUM_LO_POS = 7'd25;
    localparam logic [POS_W-1:0] SRC_IP_POS  = 7'd26;
    localparam logic [POS_W-1:0] DST_IP_POS  = 7'd30;
    localparam logic [POS_W-1:0] IP_END_POS  = 7'd34;
    localparam logic [3:0]       MIN_IHL     = 4'd5;
    localparam logic [2:0]       DST_MAC_LSB = 3'd5;
    localparam logic [3:0]       SRC_MAC_LSB = 4'd11;
    localparam logic [LIM_W-1:0] NO_LIMIT    = 8'd128;
    localparam logic [LIM_W-1:0] MIN_LIM     = LIM_W'(MIN_FRAME);
    localparam logic [CNT_W-1:0] HOLD_LIM    = CNT_W'(HOLD_DEPTH);

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
        mac_byte = 8'(mac >> {idx, 3'b000});
    endfunction

    function automatic logic [7:0] mask_byte(input logic [31:0] mask, input logic [1:0] idx);
        mask_byte = 8'(mask >> {idx, 3'b000});
    endfunction

    logic [POS_W-1:0] r_pos;
    logic [3:0]       r_hw;
    logic [15:0]      r_sum;
    logic [7:0]       r_pend;
    logic [CNT_W-1:0] r_hcnt;
    logic             r_pad;
    logic [LIM_W-1:0] r_lim;

    logic [POS_W-1:0] q;
    logic [7:0]       b;
    logic [7:0]       v;
    logic             last_step;
    logic             adv;
    logic [LIM_W-1:0] pos_inc;
    logic [LIM_W-1:0] lim_first;
    logic [LIM_W-1:0] cur_lim;
    logic [LIM_W-1:0] lim_room;
    logic [3:0]       hw_new;
    logic [POS_W-1:0] hend;
    logic [POS_W-1:0] hend_eff;
    logic             in_hdr;
    logic             hold;
    logic             flush_now;
    logic             done;
    logic [16:0]      sum17;
    logic [15:0]      sum_fold;
    logic [CNT_W-1:0] hcnt_inc;
    logic [CNT_W-1:0] hcnt_cap;
    logic [CNT_W-1:0] fcnt;

    always_comb begin
        q         = r_pos;
        b         = r_pad ? 8'h00 : i_in.in_byte;
        last_step = r_pad || i_in.in_last;
        // padding runs on its own; new bytes wait until the frame is closed
        o_in_ready = !r_pad && !i_q_full;
        adv        = !i_q_full && (r_pad || i_in_valid);

        pos_inc   = {1'b0, r_pos} + 8'd1;
        lim_first = (pos_inc > MIN_LIM) ? pos_inc : MIN_LIM;
        cur_lim   = r_pad ? r_lim : (i_in.in_last ? lim_first : NO_LIMIT);

        v = b;
        if (q < DST_MAC_END) begin
            v = mac_byte(i_peer_mac, DST_MAC_LSB - q[2:0]);
        end else if (q < SRC_MAC_END) begin
            v = mac_byte(i_local_mac, 3'(SRC_MAC_LSB - q[3:0]));
        end

        hw_new = r_hw;
        if (q == HDR_START) begin
            hw_new = (b[3:0] < MIN_IHL) ? MIN_IHL : b[3:0];
        end
        hend     = (hw_new == 4'd0) ? '0 : HDR_START + {1'b0, hw_new, 2'b00};
        hend_eff = (hw_new == 4'd0) ? IP_END_POS : hend;
        in_hdr   = (q >= HDR_START) && (q < hend);

        if (in_hdr) begin
            if (q >= SRC_IP_POS && q < DST_IP_POS) begin
                v = v ^ mask_byte(i_flip_mask, ~2'(q - SRC_IP_POS));
            end else if (q >= DST_IP_POS && q < IP_END_POS) begin
                v = v ^ mask_byte(i_flip_mask, ~2'(q - DST_IP_POS));
            end else if (q == CSUM_POS || q == CSUM_LO_POS) begin
                v = 8'h00;
            end
        end

        // end-around carry folded back each word
        sum17    = {1'b0, r_sum} + {1'b0, r_pend, v};
        sum_fold = sum17[15:0] + {15'b0, sum17[16]};

        hold      = in_hdr && (q >= CSUM_POS);
        flush_now = hold && (q == hend - 7'd1);
        hcnt_inc  = r_hcnt + 1'b1;
        hcnt_cap  = (hcnt_inc < HOLD_LIM) ? hcnt_inc : HOLD_LIM;
        lim_room  = cur_lim - {1'b0, CSUM_POS};
        fcnt      = (LIM_W'(hcnt_cap) < lim_room) ? hcnt_cap : CNT_W'(lim_room);

        done = last_step && ((pos_inc == NO_LIMIT) ||
               ((pos_inc >= MIN_LIM) && (pos_inc >= {1'b0, hend_eff})));

        o_q_push         = adv && (flush_now || (!hold && ({1'b0, q} < cur_lim)));
        o_q_cmd.is_flush = flush_now;
        o_q_cmd.data     = flush_now ? ~sum_fold : {8'h00, v};
        o_q_cmd.cnt      = fcnt;
        o_q_cmd.last     = done;

        o_ram_we    = adv && hold && (r_hcnt < HOLD_LIM);
        o_ram_waddr = r_hcnt[AW-1:0];
        o_ram_wdata = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hw   <= '0;
            r_sum  <= '0;
            r_pend <= '0;
            r_hcnt <= '0;
            r_pad  <= 1'b0;
            r_lim  <= NO_LIMIT;
        end else if (adv) begin
            if (done) begin
                r_pos  <= '0;
                r_hw   <= '0;
                r_sum  <= '0;
                r_pend <= '0;
                r_hcnt <= '0;
                r_pad  <= 1'b0;
            end else begin
                r_pos <= (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
                r_hw  <= hw_new;
                if (in_hdr) begin
                    if (q[0]) begin
                        r_sum <= sum_fold;
                    end else begin
                        r_pend <= v;
                    end
                end
                if (flush_now) begin
                    r_hcnt <= '0;
                end else if (hold) begin
                    r_hcnt <= hcnt_inc;
                end
                if (last_step) begin
                    r_pad <= 1'b1;
                    r_lim <= cur_lim;
                end
            end
        end
    end

endmodule

// ----- hdl/lfr_back.sv -----
module lfr_back #(
    parameter int HOLD_DEPTH = 50,
    parameter int AW         = $clog2(HOLD_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfr_pkg::t_cmd      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [7:0]         i_ram_rdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lfr_pkg::t_out_item o_out
);

    import lfr_pkg::*;

    localparam logic [CNT_W-1:0] HOLD_LIM = CNT_W'(HOLD_DEPTH);
    localparam logic [CNT_W-1:0] CS_HI    = 6'd0;
    localparam logic [CNT_W-1:0] CS_LO    = 6'd1;

    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_ol;
    logic             r_fact;
    logic [CNT_W-1:0] r_fi;
    logic [CNT_W-1:0] r_fn;
    logic [15:0]      r_cs;
    logic             r_flast;

    logic             n_ov;
    logic [7:0]       n_ob;
    logic             n_ol;
    logic             n_fact;
    logic [CNT_W-1:0] n_fi;
    logic [CNT_W-1:0] n_fn;
    logic [15:0]      n_cs;
    logic             n_flast;
    logic             out_free;
    logic             fl_end;

    always_comb begin
        out_free = !r_ov || i_out_ready;
        fl_end   = (r_fi == r_fn - 1'b1);
        n_ov     = r_ov && !i_out_ready;
        n_ob     = r_ob;
        n_ol     = r_ol;
        n_fact   = r_fact;
        n_fi     = r_fi;
        n_fn     = r_fn;
        n_cs     = r_cs;
        n_flast  = r_flast;
        o_pop    = 1'b0;

        if (out_free) begin
            if (r_fact) begin
                n_ov = 1'b1;
                priority if (r_fi == CS_HI) begin
                    n_ob = r_cs[15:8];
                end else if (r_fi == CS_LO) begin
                    n_ob = r_cs[7:0];
                end else begin
                    n_ob = i_ram_rdata;
                end
                n_ol = r_flast && fl_end;
                n_fi = r_fi + 1'b1;
                if (fl_end) begin
                    n_fact = 1'b0;
                end
            end else if (!i_empty) begin
                o_pop = 1'b1;
                n_ov  = 1'b1;
                if (i_head.is_flush) begin
                    // checksum high byte goes out at once
                    n_ob    = i_head.data[15:8];
                    n_ol    = i_head.last && (i_head.cnt == CS_LO);
                    n_fi    = CS_LO;
                    n_fn    = i_head.cnt;
                    n_cs    = i_head.data;
                    n_flast = i_head.last;
                    n_fact  = (i_head.cnt != CS_LO);
                end else begin
                    n_ob = i_head.data[7:0];
                    n_ol = i_head.last;
                end
            end
        end

        // read one ahead so the data lines up with r_fi
        o_ram_raddr = (n_fi < HOLD_LIM) ? n_fi[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_fact <= 1'b0;
            r_fi   <= '0;
        end else begin
            r_ov   <= n_ov;
            r_fact <= n_fact;
            r_fi   <= n_fi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob    <= n_ob;
        r_ol    <= n_ol;
        r_fn    <= n_fn;
        r_cs    <= n_cs;
        r_flast <= n_flast;
    end

    assign o_out_valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.out_last = r_ol;

endmodule

// ----- hdl/loopback_frame_rewriter.sv -----
// A pass-through byte goes from the input through the command queue into the output
// register, which presents it on the output.
// Throughput while the queue has room and the receiver is ready: one byte per cycle in
// and out; the held header (checksum field to header end) drains from RAM at one byte
// per cycle, and a short frame is padded at one byte per cycle while the input is stalled.
// Reset (synchronous, active low) returns the frame state, queue and output stage to empty
// and the registers to their defaults; the held-header RAM needs no clearing.
module loopback_frame_rewriter #(
    parameter int MIN_FRAME  = 60,
    parameter int HOLD_DEPTH = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // frame input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lfr_pkg::t_in_item  i_in_data,
    // frame output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lfr_pkg::t_out_item o_out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    import lfr_pkg::*;

    localparam int RAM_AW = $clog2(HOLD_DEPTH);

    // Register map, 8-byte stride
    localparam logic [1:0] REG_LOCAL_MAC = 2'd0;
    localparam logic [1:0] REG_PEER_MAC  = 2'd1;
    localparam logic [1:0] REG_FLIP_MASK = 2'd2;

    localparam logic [47:0] LOCAL_MAC_RST = 48'h00534E554C30;
    localparam logic [47:0] PEER_MAC_RST  = 48'h00534E554C31;
    localparam logic [31:0] FLIP_MASK_RST = 32'h00000100;

    logic [47:0] r_local_mac;
    logic [47:0] r_peer_mac;
    logic [31:0] r_flip_mask;

    logic [1:0]  reg_idx;
    logic        reg_wr;

    // ------------------------------------------------------------------
    // Register port. No wait states; a write lands in the access phase.
    // An address past the last register is ignored on write, reads as zero.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= LOCAL_MAC_RST;
            r_peer_mac  <= PEER_MAC_RST;
            r_flip_mask <= FLIP_MASK_RST;
        end else if (reg_wr) begin
            unique case (reg_idx)
                REG_LOCAL_MAC: r_local_mac <= pwdata[47:0];
                REG_PEER_MAC:  r_peer_mac  <= pwdata[47:0];
                REG_FLIP_MASK: r_flip_mask <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOCAL_MAC: prdata = {16'h0000, r_local_mac};
            REG_PEER_MAC:  prdata = {16'h0000, r_peer_mac};
            REG_FLIP_MASK: prdata = {32'h00000000, r_flip_mask};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: walks frame positions one per unstalled cycle (input bytes,
    // then pad bytes after the last one), rewrites MACs and IPv4 addresses,
    // keeps the running header checksum, parks header bytes from the
    // checksum field on in the RAM, and queues a byte or a flush command.
    // ------------------------------------------------------------------
    logic        q_full;
    logic        q_push;
    t_cmd        q_cmd;
    logic        q_pop;
    t_cmd        q_head;
    logic        q_empty;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    lfr_front #(
        .MIN_FRAME  (MIN_FRAME),
        .HOLD_DEPTH (HOLD_DEPTH),
        .AW         (RAM_AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_local_mac (r_local_mac),
        .i_peer_mac  (r_peer_mac),
        .i_flip_mask (r_flip_mask),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    // Short command queue: the front keeps taking bytes while the back
    // drains a held header, until the queue fills. Its depth is well under
    // the 24 positions before the next frame's header writes, so the RAM
    // read side never sees an entry overwritten before it is sent.
    lfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // Held header bytes; written by the front, read back by the flush.
    lfr_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH),
        .AW    (RAM_AW)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Back: pops commands into the output register; a flush sends the new
    // checksum then the held bytes. The output register decouples the
    // downstream stall from the queue.
    // ------------------------------------------------------------------
    lfr_back #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .AW         (RAM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import lfr_pkg::*;

    localparam int MIN_FRAME      = 60;
    localparam int HOLD_DEPTH     = 50;
    // one input byte can release at most this many output bytes
    localparam int MAX_STEP_OUT   = 60;
    localparam int POS_SATURATE   = 127;
    localparam int POS_OPEN_LIMIT = 128;

    // register map, one 64-bit slot per register
    localparam int REG_LOCAL_MAC  = 0;
    localparam int REG_PEER_MAC   = 1;
    localparam int REG_FLIP_MASK  = 2;
    localparam int REG_UNMAPPED   = 3;

    localparam logic [47:0] LOCAL_MAC_RST = 48'h0053_4E55_4C30;
    localparam logic [47:0] PEER_MAC_RST  = 48'h0053_4E55_4C31;
    localparam logic [31:0] FLIP_MASK_RST = 32'h0000_0100;

    localparam int PHASE_ITEMS    = 8;     // least number of random bytes per register setting
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES  = 10;    // quiet time before a register write
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // directed script row; pinned rows carry a hand-written value for the
    // first output byte caused by that transfer
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [7:0] pinned_byte;
    } t_script_row;

    localparam int SCRIPT_LEN = 17;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // one-byte frame right after reset: all padding, peer MAC first
        '{8'hFF, 1'b1, 1'b1, 8'h00},
        // 15-byte frame ending on the IHL byte with IHL 15: the header runs
        // far past the padded length, so the flushed part is cut at 60 bytes
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'hFF, 1'b0, 1'b1, 8'h53},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'hFF, 1'b0, 1'b1, 8'h53},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b1, 8'h30},
        '{8'h08, 1'b0, 1'b1, 8'h08},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h4F, 1'b1, 1'b1, 8'h4F},
        // all-zero one-byte frame
        '{8'h00, 1'b1, 1'b1, 8'h00}
    };

    // DUT connections; every input starts at a known value
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       psel        = 1'b0;
    logic       penable     = 1'b0;
    logic       pwrite      = 1'b0;
    logic [4:0] paddr       = '0;
    logic [63:0] pwdata     = '0;
    logic [63:0] prdata;
    logic       pready;

    loopback_frame_rewriter #(
        .MIN_FRAME  (MIN_FRAME),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: register copies and per-frame rewrite state
    // ---------------------------------------------------------------
    logic [47:0] cfg_local_mac;
    logic [47:0] cfg_peer_mac;
    logic [31:0] cfg_flip_mask;

    logic [6:0]  fr_pos;
    logic [3:0]  fr_hdr_words;
    logic [16:0] fr_csum;
    logic [7:0]  fr_hi_byte;
    logic [7:0]  hdr_hold [HOLD_DEPTH];
    logic [5:0]  hdr_hold_cnt;

    t_out_item   rewritten_q [$];   // expected output bytes, oldest first
    int          step_out;          // bytes released by the current transfer

    int errors       = 0;
    int bytes_in     = 0;
    int bytes_out    = 0;
    int frames_in    = 0;
    int settings_run = 1;
    int burst_left   = 0;

    function automatic int hdr_end();
        return (fr_hdr_words != 0) ? 14 + 4 * int'(fr_hdr_words) : 0;
    endfunction

    task automatic clear_frame();
        fr_pos       = '0;
        fr_hdr_words = '0;
        fr_csum      = '0;
        fr_hi_byte   = '0;
        hdr_hold_cnt = '0;
    endtask

    task automatic push_rewritten(input logic [7:0] v);
        t_out_item r;
        if (step_out < MAX_STEP_OUT) begin
            r.out_byte = v;
            r.out_last = 1'b0;
            rewritten_q.push_back(r);
            step_out++;
        end
    endtask

    // emit the held header with the finished checksum, clipped at the frame limit
    task automatic release_header(input int limit);
        logic [15:0] cs;
        int i;
        cs = ~fr_csum[15:0];
        for (i = 0; i < int'(hdr_hold_cnt) && i < HOLD_DEPTH; i++) begin
            if (24 + i >= limit)
                break;
            if (i == 0)
                push_rewritten(cs[15:8]);
            else if (i == 1)
                push_rewritten(cs[7:0]);
            else
                push_rewritten(hdr_hold[i]);
        end
        hdr_hold_cnt = '0;
    endtask

    task automatic rewrite_byte(input int pos, input logic [7:0] b, input int limit);
        logic [7:0] v;
        int hend;
        v = b;
        if (pos < 6)
            v = cfg_peer_mac[8 * (5 - pos) +: 8];
        else if (pos < 12)
            v = cfg_local_mac[8 * (11 - pos) +: 8];

        if (pos == 14)
            fr_hdr_words = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
        hend = hdr_end();

        if (pos >= 14 && pos < hend) begin
            if (pos >= 26 && pos < 30)
                v ^= cfg_flip_mask[8 * (29 - pos) +: 8];
            else if (pos >= 30 && pos < 34)
                v ^= cfg_flip_mask[8 * (33 - pos) +: 8];
            else if (pos == 24 || pos == 25)
                v = 8'h00;

            // checksum over big-endian words, folded after every add
            if (((pos - 14) & 1) == 0) begin
                fr_hi_byte = v;
            end else begin
                fr_csum = fr_csum + {1'b0, fr_hi_byte, v};
                fr_csum = {1'b0, fr_csum[15:0]} + 17'(fr_csum[16]);
            end

            // checksum field up to header end waits for the final sum
            if (pos >= 24) begin
                if (int'(hdr_hold_cnt) < HOLD_DEPTH)
                    hdr_hold[hdr_hold_cnt] = v;
                if (hdr_hold_cnt < 6'd63)
                    hdr_hold_cnt++;
                if (pos == hend - 1)
                    release_header(limit);
                return;
            end
        end
        if (pos < limit)
            push_rewritten(v);
    endtask

    // expected output for one accepted input byte
    task automatic rewrite_predict(input logic [7:0] b, input logic last);
        int pos;
        int limit;
        int q;
        int hend;
        t_out_item r;
        pos      = int'(fr_pos);
        step_out = 0;
        if (!last) begin
            rewrite_byte(pos, b, POS_OPEN_LIMIT);
            fr_pos = (pos < POS_SATURATE) ? 7'(pos + 1) : 7'(POS_SATURATE);
        end else begin
            limit = (pos + 1 > MIN_FRAME) ? pos + 1 : MIN_FRAME;
            rewrite_byte(pos, b, limit);
            // zero padding up to the minimum frame and through the header
            for (q = pos + 1; q < POS_OPEN_LIMIT; q++) begin
                hend = (fr_hdr_words != 0) ? hdr_end() : 34;
                if (q >= MIN_FRAME && q >= hend)
                    break;
                rewrite_byte(q, 8'h00, limit);
            end
            if (step_out > 0) begin
                r = rewritten_q.pop_back();
                r.out_last = 1'b1;
                rewritten_q.push_back(r);
            end
            clear_frame();
        end
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    task automatic reg_write(input int idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 8);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_LOCAL_MAC: cfg_local_mac = val[47:0];
            REG_PEER_MAC:  cfg_peer_mac  = val[47:0];
            REG_FLIP_MASK: cfg_flip_mask = val[31:0];
            default: ;     // unmapped slot, no effect
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of transfers with random gaps between them
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic pinned, input logic [7:0] pinned_byte);
        int gap;
        int base;
        t_in_item item;
        t_out_item r;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        item.in_byte = b;
        item.in_last = last;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        base = rewritten_q.size();
        rewrite_predict(b, last);
        if (pinned && rewritten_q.size() > base) begin
            r = rewritten_q[base];
            r.out_byte = pinned_byte;
            rewritten_q[base] = r;
        end
        bytes_in++;
        if (last)
            frames_in++;
    endtask

    // byte 14 is forced to the low byte of ip_byte when ip_byte is non-negative, else left random
    task automatic send_frame(input int len, input int ip_byte);
        int p;
        logic [7:0] b;
        for (p = 0; p < len; p++) begin
            b = 8'($urandom_range(0, 255));
            if (p == 14 && ip_byte >= 0)
                b = 8'(ip_byte);
            send_byte(b, p == len - 1, 1'b0, 8'h00);
        end
    endtask

    task automatic random_frame();
        int kind;
        int ihl;
        int hend;
        int len;
        kind = $urandom_range(0, 9);
        // small IHL values are rarer but still common enough to show up
        ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        hend = 14 + 4 * ((ihl < 5) ? 5 : ihl);
        if (kind <= 1)
            len = $urandom_range(1, 14);            // ends before the IHL byte
        else if (kind == 2)
            len = 15;                               // ends on the IHL byte
        else if (kind <= 5)
            len = $urandom_range(16, hend);         // header cut short or just complete
        else if (kind <= 8)
            len = $urandom_range(hend, hend + 10);  // full header plus up to 10 payload bytes
        else
            len = $urandom_range(15, 40);           // garbage version/IHL byte
        send_frame(len, (kind == 9) ? -1 : (8'h40 | ihl));
    endtask

    // stop offering, wait for every expected byte, then let the pipe go quiet
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (rewritten_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [63:0] lmac, input logic [63:0] pmac,
                             input logic [63:0] mask);
        reg_write(REG_LOCAL_MAC, lmac);
        reg_write(REG_PEER_MAC, pmac);
        reg_write(REG_FLIP_MASK, mask);
        settings_run++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: stall pattern switching between modes, plus one long hold-off
    // ---------------------------------------------------------------
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_tick      = 0;
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;
    logic     hold_arm     = 1'b0;

    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && hold_arm && i_in_valid) begin
            // sender keeps offering while the output is blocked: queue fills up
            hold_done   = 1'b1;
            hold_left   = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 80);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:     i_out_ready <= 1'b1;
                RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: i_out_ready <= ((rx_tick % 5) != 0);
                default:     i_out_ready <= 1'b1;
            endcase
        end
    end

    // output scoreboard
    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rewritten_q.size() == 0) begin
                $display("%0t: unexpected output transfer, actual byte %02h last %0b",
                         $time, o_out_data.out_byte, o_out_data.out_last);
                errors++;
            end else begin
                want = rewritten_q.pop_front();
                if (want.out_byte !== o_out_data.out_byte) begin
                    $display("%0t: out_byte mismatch, expected %02h actual %02h",
                             $time, want.out_byte, o_out_data.out_byte);
                    errors++;
                end
                if (want.out_last !== o_out_data.out_last) begin
                    $display("%0t: out_last mismatch, expected %0b actual %0b",
                             $time, want.out_last, o_out_data.out_last);
                    errors++;
                end
            end
            bytes_out++;
        end
    end

    // watchdog: ends the run after a long stretch with no transfer anywhere
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired, %0d output bytes still pending",
                 $time, rewritten_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int r;
        int start;
        cfg_local_mac = LOCAL_MAC_RST;
        cfg_peer_mac  = PEER_MAC_RST;
        cfg_flip_mask = FLIP_MASK_RST;
        clear_frame();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed script with reset register values
        for (r = 0; r < SCRIPT_LEN; r++)
            send_byte(SCRIPT[r].data, SCRIPT[r].last, SCRIPT[r].pinned,
                      SCRIPT[r].pinned_byte);
        drain_and_settle();

        // all ones, with junk above the register widths
        write_all({64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        start = bytes_in;
        while (bytes_in - start < PHASE_ITEMS)
            random_frame();
        drain_and_settle();

        // all zeros, plus a write to the unmapped slot that must be ignored
        write_all(64'h0, 64'h0, 64'h0);
        reg_write(REG_UNMAPPED, {$urandom, $urandom});
        start = bytes_in;
        while (bytes_in - start < PHASE_ITEMS)
            random_frame();
        drain_and_settle();

        write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        start = bytes_in;
        while (bytes_in - start < PHASE_ITEMS)
            random_frame();
        drain_and_settle();

        // one frame past the position counter saturation, with the long hold-off
        write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        hold_arm = 1'b1;
        send_frame($urandom_range(129, 132), 8'h45);

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (rewritten_q.size() != 0) begin
            $display("%0t: %0d expected output bytes never arrived", $time, rewritten_q.size());
            errors++;
        end
        $display("run covered %0d input bytes in %0d frames, %0d output bytes checked,",
                 bytes_in, frames_in, bytes_out);
        $display("  %0d register settings, long receiver hold-off %0s, %0d errors",
                 settings_run, hold_done ? "seen" : "not reached", errors);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lfr_pkg.sv
hdl/lfr_ram.sv
hdl/lfr_queue.sv
hdl/lfr_front.sv
hdl/lfr_back.sv
hdl/loopback_frame_rewriter.sv
dv/tb_top.sv
